// File: src/sbd_pkg.sv
package sbd_pkg;

  localparam int LEVEL_W   = 16;
  localparam int FRAME_W   = 15;
  localparam int VOL_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam int DECIMATION = 32;

  localparam logic [FRAME_W-1:0] LEVEL_MAX = 15'h7fff;
  localparam logic [VOL_W-1:0]   VOL_RESET = 7'd100;

  // level * volume < 2**23; x/100 == (x * 10737419) >> 30 for that range
  localparam int SCALE_PROD_W = LEVEL_W + VOL_W;
  localparam int SCALE_RCP_W  = 24;
  localparam int SCALE_SHIFT  = 30;
  localparam int SCALE_MUL_W  = SCALE_PROD_W + SCALE_RCP_W;
  localparam int SCALE_QUOT_W = SCALE_MUL_W - SCALE_SHIFT;
  localparam logic [SCALE_RCP_W-1:0] SCALE_RCP = 24'd10737419;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_VOLUME = 2'd0,
    REG_SOUND_ENABLED = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic acc_en;
    logic acc_last;
  } lane_ctl_t;

endpackage

// File: src/stereo_boxcar_decimator_top.sv
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tdata: left_level[15:0], right_level[31:16]
// m_axis    out  tdata: left_frame[14:0], right_frame[29:15], zero[31:30]
// cfg       in   0 master_volume[6:0], 1 sound_enabled[0]
//
// One sub-sample pair per cycle while input is not held off; one frame per DECIMATION transfers.
// A frame is built in order in the product register (loaded at the transfer that closes its group),
// then the quotient, accumulate, divide multiply and output registers.
// Reset clears sums and phase, volume to 100, sound enabled.
// Input is held off only while a new frame meets an untaken one.
module stereo_boxcar_decimator_top #(
  parameter int DECIMATION = sbd_pkg::DECIMATION
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,   // left_level, right_level
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,   // left_frame, right_frame
  input  logic                             cfg_we_i,
  input  logic [sbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sbd_pkg::VOL_W-1:0]        cfg_data_i
);

  localparam int SUM_W = sbd_pkg::FRAME_W + $clog2(DECIMATION);
  localparam int PH_W  = $clog2(DECIMATION);

  logic [sbd_pkg::VOL_W-1:0] vol_q;
  logic                      snd_q;
  logic                      v1_q, v2_q, v3_q;
  logic [PH_W-1:0]           phase_q, phase_d;
  logic                      adv, accept, last;
  sbd_pkg::lane_ctl_t        ctl;
  logic [SUM_W-1:0]          left_sum, right_sum;
  logic [sbd_pkg::FRAME_W-1:0] left_frame, right_frame;

  assign accept = s_axis_tvalid && adv;
  assign last   = (phase_q == PH_W'(DECIMATION - 1));

  assign ctl.acc_en   = v2_q && adv;
  assign ctl.acc_last = last;

  always_comb begin
    phase_d = phase_q;
    if (ctl.acc_en) begin
      phase_d = last ? '0 : phase_q + PH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q   <= sbd_pkg::VOL_RESET;
      snd_q   <= 1'b1;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      phase_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == sbd_pkg::REG_MASTER_VOLUME) begin
        vol_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == sbd_pkg::REG_SOUND_ENABLED) begin
        snd_q <= cfg_data_i[0];
      end
      if (adv) begin
        v1_q <= accept;
        v2_q <= v1_q;
        v3_q <= v2_q && last;
      end
      phase_q <= phase_d;
    end
  end

  sbd_lane #(.DECIMATION(DECIMATION), .SUM_W(SUM_W)) u_lane_l (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .level_i   (s_axis_tdata[15:0]),
    .volume_i  (vol_q),
    .ctl_i     (ctl),
    .grp_sum_o (left_sum)
  );

  sbd_lane #(.DECIMATION(DECIMATION), .SUM_W(SUM_W)) u_lane_r (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .level_i   (s_axis_tdata[31:16]),
    .volume_i  (vol_q),
    .ctl_i     (ctl),
    .grp_sum_o (right_sum)
  );

  sbd_merge #(.DECIMATION(DECIMATION), .SUM_W(SUM_W)) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grp_valid_i   (v3_q),
    .left_sum_i    (left_sum),
    .right_sum_i   (right_sum),
    .sound_en_i    (snd_q),
    .out_ready_i   (m_axis_tready),
    .adv_o         (adv),
    .out_valid_o   (m_axis_tvalid),
    .left_frame_o  (left_frame),
    .right_frame_o (right_frame)
  );

  assign s_axis_tready = adv;
  assign m_axis_tdata  = {2'b00, right_frame, left_frame};

endmodule

// File: src/sbd_lane.sv
module sbd_lane #(
  parameter int DECIMATION = sbd_pkg::DECIMATION,
  parameter int SUM_W      = sbd_pkg::FRAME_W + $clog2(DECIMATION)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [sbd_pkg::LEVEL_W-1:0]  level_i,
  input  logic [sbd_pkg::VOL_W-1:0]    volume_i,
  input  sbd_pkg::lane_ctl_t           ctl_i,
  output logic [SUM_W-1:0]             grp_sum_o
);

  logic [sbd_pkg::SCALE_PROD_W-1:0] prod_q;
  logic [sbd_pkg::SCALE_MUL_W-1:0]  mul;
  logic [sbd_pkg::SCALE_QUOT_W-1:0] quot_q;
  logic [sbd_pkg::FRAME_W-1:0]      sat;
  logic [SUM_W-1:0]                 sum_q, sum_d, grp_q, acc;

  assign mul = sbd_pkg::SCALE_MUL_W'(prod_q) * sbd_pkg::SCALE_MUL_W'(sbd_pkg::SCALE_RCP);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= sbd_pkg::SCALE_PROD_W'(level_i) * sbd_pkg::SCALE_PROD_W'(volume_i);
      quot_q <= mul[sbd_pkg::SCALE_SHIFT +: sbd_pkg::SCALE_QUOT_W];
    end
  end

  assign sat = (quot_q > sbd_pkg::SCALE_QUOT_W'(sbd_pkg::LEVEL_MAX)) ?
               sbd_pkg::LEVEL_MAX : quot_q[sbd_pkg::FRAME_W-1:0];
  assign acc = sum_q + SUM_W'(sat);

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.acc_en) begin
      sum_d = ctl_i.acc_last ? '0 : acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_en && ctl_i.acc_last) begin
      grp_q <= acc;
    end
  end

  assign grp_sum_o = grp_q;

endmodule

// File: src/sbd_merge.sv
module sbd_merge #(
  parameter int DECIMATION = sbd_pkg::DECIMATION,
  parameter int SUM_W      = sbd_pkg::FRAME_W + $clog2(DECIMATION)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        grp_valid_i,
  input  logic [SUM_W-1:0]            left_sum_i,
  input  logic [SUM_W-1:0]            right_sum_i,
  input  logic                        sound_en_i,
  input  logic                        out_ready_i,
  output logic                        adv_o,
  output logic                        out_valid_o,
  output logic [sbd_pkg::FRAME_W-1:0] left_frame_o,
  output logic [sbd_pkg::FRAME_W-1:0] right_frame_o
);

  // sum / DECIMATION as a reciprocal multiply, exact for sums below 2**SUM_W
  localparam int LOG_D = $clog2(DECIMATION);
  localparam int RCP_K = SUM_W + LOG_D;
  localparam int RCP_W = SUM_W + 1;
  localparam int MUL_W = SUM_W + RCP_W;
  localparam logic [63:0] RCP_FULL = ((64'd1 << RCP_K) + 64'(DECIMATION) - 64'd1) /
                                     64'(DECIMATION);
  localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

  logic             mul_v_q;
  logic [MUL_W-1:0] mul_l_q, mul_r_q;
  logic             out_v_q, out_v_d;
  logic [sbd_pkg::FRAME_W-1:0] left_q, right_q;
  logic             adv;

  assign adv = !(mul_v_q && out_v_q && !out_ready_i);

  always_comb begin
    out_v_d = out_v_q;
    if (adv && mul_v_q) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        mul_v_q <= grp_valid_i;
      end
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_l_q <= MUL_W'(left_sum_i) * MUL_W'(RCP);
      mul_r_q <= MUL_W'(right_sum_i) * MUL_W'(RCP);
    end
    if (adv && mul_v_q) begin
      left_q  <= sound_en_i ? mul_l_q[RCP_K +: sbd_pkg::FRAME_W] : '0;
      right_q <= sound_en_i ? mul_r_q[RCP_K +: sbd_pkg::FRAME_W] : '0;
    end
  end

  assign adv_o         = adv;
  assign out_valid_o   = out_v_q;
  assign left_frame_o  = left_q;
  assign right_frame_o = right_q;

endmodule

// File: src/sbd_checker.sv
module sbd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [31:0]                   m_axis_tdata
);

  // output held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("frame changed while stalled");

  // input is only held off behind a pending frame
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // padding above the two frames stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
    else $error("frame padding not zero");

  // input is ready again in the cycle after a frame is taken
  a_ready_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready)
    else $error("input stalled after frame transfer");

endmodule

bind stereo_boxcar_decimator_top sbd_checker u_sbd_checker (.*);
